@@ rtl/object_table_with_region_query_assert.svh @@
// Assertion macros shared by the object table checker
`ifndef OBJECT_TABLE_WITH_REGION_QUERY_ASSERT_SVH
`define OBJECT_TABLE_WITH_REGION_QUERY_ASSERT_SVH

// same-cycle implication
`define OTRQ_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("object table assertion failed");

// next-cycle implication
`define OTRQ_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("object table assertion failed");

`endif

@@ rtl/otrq_pkg.sv @@
// Types and constants of the object table with region query
package otrq_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] OP_ADD        = 3'd0;
    localparam logic [2:0] OP_MODIFY     = 3'd1;
    localparam logic [2:0] OP_DELETE     = 3'd2;
    localparam logic [2:0] OP_QUERY      = 3'd3;
    localparam logic [2:0] OP_QUERY_ITEM = 3'd4;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_MATCH     = 3'd3;
    localparam logic [2:0] ST_NO_MATCH  = 3'd4;

    typedef struct packed {
        logic [31:0]        id;
        logic [15:0]        item;
        logic [7:0]         count;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [7:0]         flags;
    } entry_t;

    typedef enum logic [1:0] {
        MODE_ID,
        MODE_RECT,
        MODE_RECT_ITEM
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DEL_RD,
        S_DEL_WR,
        S_FLUSH
    } state_t;

endpackage

@@ rtl/otrq_ram.sv @@
// Entry store: one write port, one registered read port
module otrq_ram (
    input  logic                        clk,
    input  logic                        we,
    input  logic [otrq_pkg::ADDR_W-1:0] waddr,
    input  otrq_pkg::entry_t            wdata,
    input  logic [otrq_pkg::ADDR_W-1:0] raddr,
    output otrq_pkg::entry_t            rdata
);
    import otrq_pkg::*;

    entry_t mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/otrq_match.sv @@
// Shared compare unit: id match or inclusive rectangle test with item filter
module otrq_match (
    input  otrq_pkg::entry_t   ent,
    input  otrq_pkg::mode_t    mode,
    input  logic [31:0]        key_id,
    input  logic [15:0]        key_item,
    input  logic signed [31:0] x_min,
    input  logic signed [31:0] y_min,
    input  logic signed [31:0] x_max,
    input  logic signed [31:0] y_max,
    output logic               hit
);
    import otrq_pkg::*;

    logic in_rect;

    assign in_rect = (x_min <= ent.x) && (ent.x <= x_max) &&
                     (y_min <= ent.y) && (ent.y <= y_max);

    always_comb
    begin
        unique case (mode)
            MODE_ID:        hit = (ent.id == key_id);
            MODE_RECT:      hit = in_rect;
            MODE_RECT_ITEM: hit = in_rect && (ent.item == key_item);
            default:        hit = 1'b0;
        endcase
    end

endmodule

@@ rtl/object_table_with_region_query.sv @@
// Object table with region query: top level and sequencer
//
// Up to 64 objects live in a single-port-read table memory, and one shared
// compare unit checks one entry per clock unless a query result is stalled.
// An add answers the cycle after it is accepted. Modify, delete and both
// region queries scan the used entries in table order: a modify answers once
// it finds its id, a delete then reads the last entry and moves it into the
// freed slot; a miss or a query answers after the scan and a flush step.
// While a query result sits stalled in the output register, the next match
// is read and checked again until the stall ends, so the scan waits it out.
// Results leave through an output register; one transaction is worked on at
// a time.
module object_table_with_region_query (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         op,
    input  logic [31:0]        object_id,
    input  logic [15:0]        item_number,
    input  logic [7:0]         item_count,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic [7:0]         item_flags,
    input  logic signed [31:0] rect_x_min,
    input  logic signed [31:0] rect_y_min,
    input  logic signed [31:0] rect_x_max,
    input  logic signed [31:0] rect_y_max,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [31:0]        res_object_id,
    output logic [15:0]        res_item_number,
    output logic [7:0]         res_item_count,
    output logic signed [31:0] res_pos_x,
    output logic signed [31:0] res_pos_y,
    output logic [7:0]         res_item_flags,
    output logic               last
);
    import otrq_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [31:0]        next_id_reg, next_id_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               chk_v_reg, chk_v_next;
    logic [ADDR_W-1:0]  chk_idx_reg, chk_idx_next;
    logic [ADDR_W-1:0]  pos_reg, pos_next;
    logic               pend_v_reg, pend_v_next;
    entry_t             pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    entry_t             out_reg, out_next;
    logic [2:0]         status_reg, status_next;
    logic               last_reg, last_next;

    logic [2:0]         op_reg, op_next;
    entry_t             key_reg, key_next;
    logic signed [31:0] xmin_reg, xmin_next;
    logic signed [31:0] ymin_reg, ymin_next;
    logic signed [31:0] xmax_reg, xmax_next;
    logic signed [31:0] ymax_reg, ymax_next;

    logic               we;
    logic [ADDR_W-1:0]  waddr, raddr;
    entry_t             wdata, rdata;
    mode_t              mode;
    logic               hit;
    logic               in_acc, out_free;
    entry_t             fresh;

    otrq_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    otrq_match u_match (
        .ent      (rdata),
        .mode     (mode),
        .key_id   (key_reg.id),
        .key_item (key_reg.item),
        .x_min    (xmin_reg),
        .y_min    (ymin_reg),
        .x_max    (xmax_reg),
        .y_max    (ymax_reg),
        .hit      (hit)
    );

    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign fresh = '{id: next_id_reg, item: item_number, count: item_count,
                     x: pos_x, y: pos_y, flags: item_flags};

    always_comb
    begin
        unique case (op_reg)
            OP_MODIFY, OP_DELETE: mode = MODE_ID;
            OP_QUERY_ITEM:        mode = MODE_RECT_ITEM;
            default:              mode = MODE_RECT;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        next_id_next   = next_id_reg;
        idx_next       = idx_reg;
        chk_v_next     = 1'b0;
        chk_idx_next   = chk_idx_reg;
        pos_next       = pos_reg;
        pend_v_next    = pend_v_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        xmin_next      = xmin_reg;
        ymin_next      = ymin_reg;
        xmax_next      = xmax_reg;
        ymax_next      = ymax_reg;
        we             = 1'b0;
        waddr          = count_reg[ADDR_W-1:0];
        wdata          = fresh;
        raddr          = idx_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_next   = op;
                    key_next  = '{id: object_id, item: item_number, count: item_count,
                                  x: pos_x, y: pos_y, flags: item_flags};
                    xmin_next = rect_x_min;
                    ymin_next = rect_y_min;
                    xmax_next = rect_x_max;
                    ymax_next = rect_y_max;
                    unique case (op)
                        OP_ADD:
                        begin
                            out_valid_next = 1'b1;
                            last_next      = 1'b1;
                            if (count_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                status_next = ST_FULL;
                                out_next    = '0;
                            end
                            else
                            begin
                                we           = 1'b1;
                                status_next  = ST_DONE;
                                out_next     = fresh;
                                count_next   = count_reg + 1'b1;
                                next_id_next = next_id_reg + 1'b1;
                            end
                        end
                        OP_MODIFY, OP_DELETE, OP_QUERY, OP_QUERY_ITEM:
                        begin
                            idx_next    = '0;
                            pend_v_next = 1'b0;
                            state_next  = S_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (idx_reg < count_reg)
                begin
                    chk_v_next   = 1'b1;
                    chk_idx_next = idx_reg[ADDR_W-1:0];
                    idx_next     = idx_reg + 1'b1;
                end
                if (!chk_v_reg && (idx_reg >= count_reg))
                begin
                    state_next = S_FLUSH;
                end
                if (chk_v_reg && hit)
                begin
                    priority case (op_reg)
                        OP_MODIFY:
                        begin
                            we             = 1'b1;
                            waddr          = chk_idx_reg;
                            wdata          = key_reg;
                            out_next       = key_reg;
                            status_next    = ST_DONE;
                            last_next      = 1'b1;
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                        OP_DELETE:
                        begin
                            out_next    = rdata;
                            status_next = ST_DONE;
                            last_next   = 1'b1;
                            pos_next    = chk_idx_reg;
                            state_next  = S_DEL_RD;
                        end
                        default:
                        begin
                            if (!pend_v_reg)
                            begin
                                pend_v_next = 1'b1;
                                pend_next   = rdata;
                            end
                            else if (out_free)
                            begin
                                out_next       = pend_reg;
                                status_next    = ST_MATCH;
                                last_next      = 1'b0;
                                out_valid_next = 1'b1;
                                pend_next      = rdata;
                            end
                            else
                            begin
                                // output busy: retry this entry
                                idx_next   = {1'b0, chk_idx_reg};
                                chk_v_next = 1'b0;
                            end
                        end
                    endcase
                end
            end
            S_DEL_RD:
            begin
                raddr      = ADDR_W'(count_reg - 1'b1);
                state_next = S_DEL_WR;
            end
            S_DEL_WR:
            begin
                we             = 1'b1;
                waddr          = pos_reg;
                wdata          = rdata;
                count_next     = count_reg - 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                    if ((op_reg == OP_MODIFY) || (op_reg == OP_DELETE))
                    begin
                        status_next = ST_NOT_FOUND;
                        out_next    = '0;
                        out_next.id = key_reg.id;
                    end
                    else if (pend_v_reg)
                    begin
                        status_next = ST_MATCH;
                        out_next    = pend_reg;
                    end
                    else
                    begin
                        status_next = ST_NO_MATCH;
                        out_next    = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            next_id_reg   <= '0;
            idx_reg       <= '0;
            chk_v_reg     <= 1'b0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            idx_reg       <= idx_next;
            chk_v_reg     <= chk_v_next;
            pend_v_reg    <= pend_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
        pos_reg     <= pos_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
        status_reg  <= status_next;
        last_reg    <= last_next;
        op_reg      <= op_next;
        key_reg     <= key_next;
        xmin_reg    <= xmin_next;
        ymin_reg    <= ymin_next;
        xmax_reg    <= xmax_next;
        ymax_reg    <= ymax_next;
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign res_object_id   = out_reg.id;
    assign res_item_number = out_reg.item;
    assign res_item_count  = out_reg.count;
    assign res_pos_x       = out_reg.x;
    assign res_pos_y       = out_reg.y;
    assign res_item_flags  = out_reg.flags;
    assign last            = last_reg;

endmodule

@@ rtl/otrq_checker.sv @@
// Port-level checker for the object table, bound to the top level
`include "object_table_with_region_query_assert.svh"

module otrq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [2:0]  op,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [31:0] res_object_id,
    input logic        last
);
    import otrq_pkg::*;

    logic        out_held, in_add, add_ok;
    logic [34:0] out_word;

    assign out_held = out_valid && out_stall;
    assign in_add   = in_valid && !in_stall && (op == OP_ADD);
    assign add_ok   = (status == ST_DONE) || (status == ST_FULL);
    assign out_word = {status, res_object_id};

    `OTRQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_held, out_valid && $stable(out_word))
    `OTRQ_ASSERT_IMP(a_single_last, clk, rst_n, out_valid && (status != ST_MATCH), last)
    `OTRQ_ASSERT_IMP(a_one_at_a_time, clk, rst_n, out_valid, in_stall)
    `OTRQ_ASSERT_NXT(a_add_result, clk, rst_n, in_add, out_valid && last && add_ok)

endmodule

bind object_table_with_region_query otrq_checker u_otrq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .res_object_id (res_object_id),
    .last          (last)
);
